// ===== rtl/utda_pkg.sv =====
package utda_pkg;

  // Field widths of the input and result words.
  localparam int unsigned NUM_W    = 16;
  localparam int unsigned MINLEN_W = 4;
  localparam int unsigned FRAC_W   = 3;
  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned POS_W    = 3;
  localparam int unsigned LEN_W    = 4;

  // Five BCD digits cover every 16-bit value.
  localparam int unsigned BCD_DIGITS = 5;
  localparam int unsigned BCD_W      = 4 * BCD_DIGITS;
  localparam int unsigned STEP_W     = $clog2(NUM_W + 1);

  localparam int unsigned MAX_LEN_DEF = 8;

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0] ASCII_POINT = 8'd46;

  typedef logic [NUM_W-1:0] number_t;
  typedef logic [BCD_W-1:0] bcd_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CONV = 3'b010,
    ST_EMIT = 3'b100
  } state_e;

  // Status of the shift-and-add-three converter.
  typedef struct packed {
    logic busy;
    logic done;
  } dabble_status_t;

endpackage

// ===== rtl/utda_if.sv =====
interface utda_in_if;
  import utda_pkg::*;

  logic                valid;
  logic                ready;
  logic [NUM_W-1:0]    number;
  logic [MINLEN_W-1:0] min_length;
  logic [FRAC_W-1:0]   fraction_digits;

  modport source (output valid, number, min_length, fraction_digits, input ready);
  modport sink   (input valid, number, min_length, fraction_digits, output ready);
endinterface

interface utda_out_if;
  import utda_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] character;
  logic [POS_W-1:0]  position;
  logic [LEN_W-1:0]  length;
  logic              last;

  modport source (output valid, character, position, length, last, input ready);
  modport sink   (input valid, character, position, length, last, output ready);
endinterface

// ===== rtl/utda_dabble.sv =====
module utda_dabble (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  utda_pkg::number_t         number_i,
  output utda_pkg::dabble_status_t  status_o,
  output utda_pkg::bcd_t            bcd_o
);
  import utda_pkg::*;

  number_t           shift_q, shift_d;
  bcd_t              bcd_q, bcd_d;
  logic [STEP_W-1:0] cnt_q, cnt_d;
  bcd_t              adj;

  // One shift-and-add-three step per cycle, one input bit at a time.
  always_comb begin
    adj = bcd_q;
    for (int d = 0; d < BCD_DIGITS; d++) begin
      if (bcd_q[d*4 +: 4] >= 4'd5) begin
        adj[d*4 +: 4] = bcd_q[d*4 +: 4] + 4'd3;
      end
    end
    if (start_i) begin
      shift_d = number_i;
      bcd_d   = '0;
      cnt_d   = STEP_W'(NUM_W);
    end else if (cnt_q != '0) begin
      shift_d = {shift_q[NUM_W-2:0], 1'b0};
      bcd_d   = {adj[BCD_W-2:0], shift_q[NUM_W-1]};
      cnt_d   = cnt_q - 1'b1;
    end else begin
      shift_d = shift_q;
      bcd_d   = bcd_q;
      cnt_d   = cnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
    bcd_q   <= bcd_d;
  end

  assign status_o.busy = (cnt_q != '0);
  assign status_o.done = (cnt_q == STEP_W'(1));
  assign bcd_o         = bcd_q;

endmodule

// ===== rtl/unsigned_to_decimal_ascii_unit.sv =====
// Unsigned binary to ASCII decimal text with zero padding and a decimal point.
//
// The input channel carries a word with a 16-bit number, a minimum field length
// and a count of fraction digits. The output channel returns the text one
// character per word, most significant first, with its position, the total
// length of the string and a flag on the final character.
//
// An accepted word is first converted to BCD by a shift-and-add-three unit that
// takes one input bit per cycle. The characters then follow at one per cycle
// while the receiver takes them, the first as soon as conversion has finished.
// The input channel is ready only while no item is in work; it is ready again
// in the cycle after the final character has been taken.
//
// When the receiver stalls, the current character is held unchanged and the
// sequence simply pauses. Reset returns the block to idle, ready for a word,
// with nothing valid on the output.
module unsigned_to_decimal_ascii_unit #(
  parameter int unsigned MAX_LEN = utda_pkg::MAX_LEN_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  utda_in_if.sink    in_i,
  utda_out_if.source out_o
);
  import utda_pkg::*;

  // Counter width for lengths and positions; the sum width leaves room for
  // the uncapped length before saturation.
  localparam int unsigned LW = $clog2(MAX_LEN + 1);
  localparam int unsigned TW = LW + 1;

  state_e          state_q, state_d;
  logic [LW-1:0]   len_q, len_d;
  logic [LW-1:0]   pos_q, pos_d;
  logic [LW-1:0]   pointpos_q, pointpos_d;
  logic            has_point_q, has_point_d;

  dabble_status_t  cv_status;
  bcd_t            bcd;
  logic            start;

  logic [TW-1:0]   digits;
  logic [TW-1:0]   tlen;
  logic [TW-1:0]   nd_ext;
  logic [LW-1:0]   nd_lw;
  logic [LW-1:0]   rem;
  logic [LW-1:0]   dig_idx;
  logic [3:0]      dig;
  logic            is_point;
  logic            in_acc, out_acc;
  logic [LW+LEN_W-1:0] len_wide;

  assign in_acc  = in_i.valid && in_i.ready;
  assign out_acc = out_o.valid && out_o.ready;
  assign start   = in_acc;

  utda_dabble u_dabble (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .number_i (in_i.number),
    .status_o (cv_status),
    .bcd_o    (bcd)
  );

  // String length from the incoming word: natural digit count, one more for
  // the point, raised to the minimum and to room for a leading digit, capped.
  always_comb begin
    nd_ext = TW'(in_i.fraction_digits);
    nd_lw  = LW'(in_i.fraction_digits);
    digits = TW'(1);
    if (in_i.number >= NUM_W'(10))    digits = digits + 1'b1;
    if (in_i.number >= NUM_W'(100))   digits = digits + 1'b1;
    if (in_i.number >= NUM_W'(1000))  digits = digits + 1'b1;
    if (in_i.number >= NUM_W'(10000)) digits = digits + 1'b1;
    tlen = digits + ((nd_ext != '0) ? TW'(1) : TW'(0));
    if (tlen < TW'(in_i.min_length)) begin
      tlen = TW'(in_i.min_length);
    end
    if ((nd_ext != '0) && (tlen < nd_ext + TW'(2))) begin
      tlen = nd_ext + TW'(2);
    end
    if (tlen > TW'(MAX_LEN)) begin
      tlen = TW'(MAX_LEN);
    end
  end

  // Next-state logic of the sequencer.
  always_comb begin
    state_d     = state_q;
    len_d       = len_q;
    pos_d       = pos_q;
    pointpos_d  = pointpos_q;
    has_point_d = has_point_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          len_d       = tlen[LW-1:0];
          pos_d       = '0;
          has_point_d = (nd_lw != '0) && (tlen[LW-1:0] > nd_lw);
          pointpos_d  = tlen[LW-1:0] - nd_lw - LW'(1);
          state_d     = ST_CONV;
        end
      end
      ST_CONV: begin
        if (cv_status.done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_acc) begin
          if (out_o.last) begin
            state_d = ST_IDLE;
          end else begin
            pos_d = pos_q + 1'b1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pos_q   <= '0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    len_q       <= len_d;
    pointpos_q  <= pointpos_d;
    has_point_q <= has_point_d;
  end

  // Digit selection: count the digit places to the right of this position,
  // skipping the point when it lies to the right.
  always_comb begin
    is_point = has_point_q && (pos_q == pointpos_q);
    rem      = len_q - LW'(1) - pos_q;
    dig_idx  = rem - ((has_point_q && (pos_q < pointpos_q)) ? LW'(1) : LW'(0));
    dig      = 4'd0;
    for (int d = 0; d < BCD_DIGITS; d++) begin
      if (dig_idx == LW'(d)) begin
        dig = bcd[d*4 +: 4];
      end
    end
  end

  assign len_wide = {{LEN_W{1'b0}}, len_q};

  assign in_i.ready      = (state_q == ST_IDLE);
  assign out_o.valid     = (state_q == ST_EMIT);
  assign out_o.character = is_point ? ASCII_POINT : (ASCII_ZERO + {4'b0000, dig});
  assign out_o.position  = pos_q[POS_W-1:0];
  assign out_o.length    = len_wide[LEN_W-1:0];
  assign out_o.last      = (pos_q == len_q - LW'(1));

  // The input side is never open while a character is on offer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_i.ready && out_o.valid))
    else $error("input ready while a character is pending");

  // The final character sits at the last position of the string.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.last) |-> (out_o.position == 3'(out_o.length - 4'd1)))
    else $error("last flag away from the final position");

  // Taking the final character frees the block for the next word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.ready && out_o.last) |=> in_i.ready)
    else $error("block not ready after the final character");

  // The converter finishes only while the sequencer waits for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cv_status.done |-> (state_q == ST_CONV))
    else $error("conversion finished outside the conversion phase");

endmodule
